// ===== rtl/glzw_pkg.sv =====
// shared types and constants for the gif lzw pixel decoder
package glzw_pkg;

  // item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_PULL  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_PIXEL    = 3'd0;
  localparam logic [2:0] ST_NEED     = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_SEQ_ERR  = 3'd4;
  localparam logic [2:0] ST_REFUSED  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_CODE_SIZE = 3'd0;
  localparam logic [2:0] REG_IMAGE_LEFT    = 3'd1;
  localparam logic [2:0] REG_IMAGE_TOP     = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_INTERLACED    = 3'd5;

  localparam int unsigned CODE_W = 13;
  localparam logic [12:0] NO_CODE = 13'h1FFF;

  // one classified item passed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } glzw_cmd_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pixel_index;
    logic [15:0] column;
    logic [15:0] row;
    logic        last_pixel;
  } glzw_res_t;

endpackage

// ===== rtl/glzw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/glzw_front.sv =====
// front end: input acceptance and a two-entry item queue
module glzw_front import glzw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  output logic       q_valid,
  output glzw_cmd_t  q_cmd,
  input  logic       q_take
);
  glzw_cmd_t  ent_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = ent_r[rd_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= '{kind: in_kind, data_byte: in_data_byte};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_take && q_valid) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take && q_valid};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !(q_take && q_valid)) else $error("take from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> in_stall) else $error("full queue not stalling");
endmodule

// ===== rtl/glzw_back.sv =====
// back end: lzw decode engine, expansion stack and pixel position
module glzw_back import glzw_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  glzw_cmd_t   q_cmd,
  output logic        q_take,
  input  logic [3:0]  min_code_size,
  input  logic [15:0] image_left,
  input  logic [15:0] image_top,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  input  logic        interlaced,
  output logic        res_valid,
  output glzw_res_t   res,
  input  logic        res_take
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int SW = AW + 1;
  localparam logic [12:0] TBL_END = 13'(TABLE_ENTRIES);
  localparam logic [3:0] MAX_W = 4'(MAX_CODE_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FC_RD, S_FC_WAIT, S_ADD, S_EX_RD, S_EX_WAIT,
    S_POP_RD, S_POP_WAIT, S_OUT
  } state_t;

  state_t      state_r;
  logic [12:0] nfc_r, prev_r, code_r, walk_r;
  logic [3:0]  cw_r;
  logic [19:0] buf_r;
  logic [4:0]  bcnt_r;
  logic [SW-1:0] sd_r;
  logic [AW:0] guard_r;
  logic [15:0] col_r, row_r;
  logic        fin_r;
  logic [7:0]  fc_r;
  glzw_res_t   res_r;
  logic        rv_r;

  // ram ports
  logic          pre_we, suf_we, stk_we;
  logic [AW-1:0] tbl_wa, tbl_ra, stk_wa, stk_ra;
  logic [12:0]   pre_wd, pre_rd;
  logic [7:0]    suf_wd, suf_rd, stk_wd, stk_rd;

  glzw_ram #(.WIDTH(13), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk, .wr_en(pre_we), .wr_addr(tbl_wa), .wr_data(pre_wd),
    .rd_addr(tbl_ra), .rd_data(pre_rd));
  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk, .wr_en(suf_we), .wr_addr(tbl_wa), .wr_data(suf_wd),
    .rd_addr(tbl_ra), .rd_data(suf_rd));
  glzw_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
    .rd_addr(stk_ra), .rd_data(stk_rd));

  // effective code sizes
  logic [3:0]  mcs;
  logic [12:0] clr;
  logic [15:0] w_eff, h_eff;
  always_comb begin
    mcs = (min_code_size < 4'd2) ? 4'd2 : (min_code_size > 4'd8) ? 4'd8 : min_code_size;
    clr = 13'd1 << mcs;
    w_eff = (image_width == '0) ? 16'd1 : image_width;
    h_eff = (image_height == '0) ? 16'd1 : image_height;
  end

  // next code from the bit buffer
  logic [12:0] code_now;
  assign code_now = 13'(buf_r & ((20'd1 << cw_r) - 20'd1));

  // chain walk helper
  logic walk_is_tbl;
  assign walk_is_tbl = (walk_r >= clr) && (walk_r < TBL_END);

  // position advance
  logic [15:0] col_inc, adv_row;
  logic        adv_wrap, adv_done;
  logic [16:0] v17;
  always_comb begin
    col_inc  = col_r + 16'd1;
    adv_wrap = (col_inc >= w_eff) || (col_inc == 16'd0);
    adv_done = 1'b0;
    adv_row  = row_r;
    v17      = {1'b0, row_r};
    if (adv_wrap) begin
      if (interlaced) begin
        case (row_r[2:0])
          3'd0: begin
            v17 = {1'b0, row_r} + 17'd8;
            if (v17 < {1'b0, h_eff}) adv_row = v17[15:0];
            else if (h_eff > 16'd4) adv_row = 16'd4;
            else if (h_eff > 16'd2) adv_row = 16'd2;
            else if (h_eff > 16'd1) adv_row = 16'd1;
            else adv_done = 1'b1;
          end
          3'd4: begin
            v17 = {1'b0, row_r} + 17'd8;
            adv_row = (v17 >= {1'b0, h_eff}) ? 16'd2 : v17[15:0];
          end
          3'd2, 3'd6: begin
            v17 = {1'b0, row_r} + 17'd4;
            adv_row = (v17 >= {1'b0, h_eff}) ? 16'd1 : v17[15:0];
          end
          default: begin
            v17 = {1'b0, row_r} + 17'd2;
            adv_done = (v17 >= {1'b0, h_eff});
            adv_row = v17[15:0];
          end
        endcase
      end else begin
        v17 = {1'b0, row_r} + 17'd1;
        adv_done = (v17 >= {1'b0, h_eff});
        adv_row = v17[15:0];
      end
    end
  end

  // ram port drive
  always_comb begin
    pre_we = 1'b0; suf_we = 1'b0; stk_we = 1'b0;
    tbl_wa = nfc_r[AW-1:0];
    pre_wd = prev_r;
    suf_wd = fc_r;
    tbl_ra = walk_r[AW-1:0];
    stk_wa = sd_r[AW-1:0];
    stk_wd = 8'(walk_r);
    stk_ra = AW'(sd_r - SW'(1));
    if (state_r == S_ADD) begin
      pre_we = 1'b1; suf_we = 1'b1;
    end
    if (state_r == S_EX_RD && !walk_is_tbl) stk_we = 1'b1;
    if (state_r == S_EX_WAIT) begin
      stk_we = 1'b1;
      stk_wd = suf_rd;
    end
    if (state_r == S_EX_WAIT || state_r == S_EX_RD) stk_wa = sd_r[AW-1:0];
  end

  assign q_take    = (state_r == S_IDLE) && q_valid && !(rv_r && !res_take);
  assign res_valid = rv_r;
  assign res       = res_r;

  // decode sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nfc_r <= '0; cw_r <= '0; prev_r <= NO_CODE;
      buf_r <= '0; bcnt_r <= '0; sd_r <= '0;
      col_r <= '0; row_r <= '0; fin_r <= 1'b1;
      rv_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_take) begin
            case (q_cmd.kind)
              KIND_START: begin
                nfc_r <= clr + 13'd2; cw_r <= mcs + 4'd1; prev_r <= NO_CODE;
                buf_r <= '0; bcnt_r <= '0; sd_r <= '0;
                col_r <= '0; row_r <= '0; fin_r <= 1'b0;
                res_r <= '{status: ST_NEED, default: '0}; rv_r <= 1'b1;
              end
              KIND_PUSH: begin
                rv_r <= 1'b1;
                if (fin_r) res_r <= '{status: ST_ACCEPTED, default: '0};
                else if (bcnt_r >= 5'd12) res_r <= '{status: ST_REFUSED, default: '0};
                else begin
                  buf_r <= buf_r | (20'(q_cmd.data_byte) << bcnt_r);
                  bcnt_r <= bcnt_r + 5'd8;
                  res_r <= '{status: ST_ACCEPTED, default: '0};
                end
              end
              default: begin
                if (fin_r) begin
                  res_r <= '{status: ST_FINISHED, default: '0}; rv_r <= 1'b1;
                end else begin
                  res_r <= '0; rv_r <= 1'b0;
                  if (sd_r != '0) state_r <= S_POP_RD;
                  else state_r <= S_DECODE;
                end
              end
            endcase
          end else if (rv_r && res_take) rv_r <= 1'b0;
        end
        S_DECODE: begin
          if (cw_r == 4'd0 || cw_r > MAX_W) begin
            nfc_r <= clr + 13'd2; cw_r <= mcs + 4'd1; prev_r <= NO_CODE;
          end else if (bcnt_r < 5'(cw_r)) begin
            res_r.status <= ST_NEED; rv_r <= 1'b1; state_r <= S_IDLE;
          end else begin
            buf_r <= buf_r >> cw_r;
            bcnt_r <= bcnt_r - 5'(cw_r);
            code_r <= code_now;
            if (code_now == clr + 13'd1) begin
              fin_r <= 1'b1; sd_r <= '0;
              res_r.status <= ST_FINISHED; rv_r <= 1'b1; state_r <= S_IDLE;
            end else if (code_now == clr) begin
              nfc_r <= clr + 13'd2; cw_r <= mcs + 4'd1; prev_r <= NO_CODE;
            end else if (code_now < nfc_r) begin
              walk_r <= code_now; guard_r <= '0;
              if (nfc_r < TBL_END && prev_r != NO_CODE) state_r <= S_FC_RD;
              else state_r <= S_EX_RD;
            end else if (code_now == nfc_r && prev_r != NO_CODE && nfc_r < TBL_END) begin
              walk_r <= prev_r; guard_r <= '0; state_r <= S_FC_RD;
            end else begin
              fin_r <= 1'b1; sd_r <= '0;
              res_r.status <= ST_SEQ_ERR; rv_r <= 1'b1; state_r <= S_IDLE;
            end
          end
        end
        // first character: follow prefixes to a root
        S_FC_RD: begin
          if (!walk_is_tbl) begin
            fc_r <= 8'(walk_r); state_r <= S_ADD;
          end else state_r <= S_FC_WAIT;
        end
        S_FC_WAIT: begin
          if (guard_r == (AW+1)'(TABLE_ENTRIES - 1)) begin
            fc_r <= suf_rd; state_r <= S_ADD;
          end else begin
            walk_r <= pre_rd; guard_r <= guard_r + 1'b1; state_r <= S_FC_RD;
          end
        end
        S_ADD: begin
          nfc_r <= nfc_r + 13'd1;
          if (cw_r < MAX_W && (nfc_r + 13'd1) == (13'd1 << cw_r)) cw_r <= cw_r + 4'd1;
          walk_r <= code_r; sd_r <= '0; state_r <= S_EX_RD;
        end
        // expansion onto the stack
        S_EX_RD: begin
          if (!walk_is_tbl) begin
            sd_r <= sd_r + 1'b1; state_r <= S_POP_RD;
          end else state_r <= S_EX_WAIT;
          prev_r <= code_r;
        end
        S_EX_WAIT: begin
          sd_r <= sd_r + 1'b1;
          walk_r <= pre_rd;
          if (sd_r + 1'b1 == SW'(TABLE_ENTRIES)) state_r <= S_POP_RD;
          else state_r <= S_EX_RD;
        end
        S_POP_RD: state_r <= S_POP_WAIT;
        S_POP_WAIT: begin
          res_r.status <= ST_PIXEL;
          res_r.pixel_index <= stk_rd;
          res_r.column <= image_left + col_r;
          res_r.row <= image_top + row_r;
          res_r.last_pixel <= adv_done;
          col_r <= adv_wrap ? 16'd0 : col_inc;
          if (adv_done) begin
            fin_r <= 1'b1; sd_r <= '0;
          end else begin
            sd_r <= sd_r - 1'b1;
            row_r <= adv_row;
          end
          rv_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_code: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !(rv_r && !res_take)) else $error("item taken over pending result");
  a_bits: assert property (@(posedge clk) disable iff (!rst_n) bcnt_r <= 5'd20)
    else $error("bit buffer overflow");
  a_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rv_r) && res_r.last_pixel |-> fin_r) else $error("last pixel without finish");
endmodule

// ===== rtl/gif_lzw_pixel_decoder.sv =====
// top level of the gif lzw pixel decoder
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_kind, in_data_byte
// out     | output    | out_valid, out_stall, out_status .. out_last_pixel
// cfg     | input     | cfg_we, cfg_index, cfg_data
// a start or push item gives its result from the back end's result register; a pull
// from a full stack pops a pixel from the stack ram; a pull that expands a code walks
// its prefix chain one entry at a time on the table ram read port, twice when a new entry is added.
// rst_n is synchronous; no clearing pass, table entries are defined by writes.
// a two-item queue lets the input proceed while the back end or output stalls.
module gif_lzw_pixel_decoder import glzw_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_pixel_index,
  output logic [15:0] out_column,
  output logic [15:0] out_row,
  output logic        out_last_pixel,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [3:0]  mcs_r;
  logic [15:0] left_r, top_r, width_r, height_r;
  logic        il_r;
  logic        q_valid, q_take;
  glzw_cmd_t   q_cmd;
  glzw_res_t   res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r <= 4'd8; left_r <= '0; top_r <= '0;
      width_r <= 16'd1; height_r <= 16'd1; il_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CODE_SIZE: mcs_r <= cfg_data[3:0];
        REG_IMAGE_LEFT:    left_r <= cfg_data;
        REG_IMAGE_TOP:     top_r <= cfg_data;
        REG_IMAGE_WIDTH:   width_r <= cfg_data;
        REG_IMAGE_HEIGHT:  height_r <= cfg_data;
        REG_INTERLACED:    il_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  glzw_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_data_byte,
    .q_valid, .q_cmd, .q_take);

  glzw_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take,
    .min_code_size(mcs_r), .image_left(left_r), .image_top(top_r),
    .image_width(width_r), .image_height(height_r), .interlaced(il_r),
    .res_valid(out_valid), .res, .res_take(!out_stall));

  assign out_status      = res.status;
  assign out_pixel_index = res.pixel_index;
  assign out_column      = res.column;
  assign out_row         = res.row;
  assign out_last_pixel  = res.last_pixel;
endmodule

// ===== tb/gif_lzw_pixel_decoder_test.sv =====
// self-checking testbench for the gif lzw pixel decoder
module gif_lzw_pixel_decoder_test;
  import glzw_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned ENTRIES = 4096;
  localparam int unsigned WIDEST = 12;
  localparam int unsigned REFUSE_AT = 12;
  localparam int unsigned LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [7:0]  out_pixel_index;
  logic [15:0] out_column;
  logic [15:0] out_row;
  logic        out_last_pixel;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  gif_lzw_pixel_decoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_pixel_index(out_pixel_index), .out_column(out_column), .out_row(out_row),
    .out_last_pixel(out_last_pixel),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder registers as the predictor sees them
  logic [3:0]  cur_mcs;
  logic [15:0] cur_left, cur_top, cur_width, cur_height;
  logic        cur_ilace;

  // predicted decoder state
  int unsigned code_prefix [ENTRIES];
  logic [7:0]  code_suffix [ENTRIES];
  logic [7:0]  pixel_stack [ENTRIES];
  int unsigned stack_fill, free_code, width_bits, last_code;
  int unsigned bit_store, bits_held, col_pos, row_pos;
  bit          image_done;

  glzw_res_t   pending_results[$];
  int unsigned items_sent;
  int unsigned pixels_seen;
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet;

  // compressed stream under construction
  logic [7:0]  stream_q[$];
  int unsigned feed_pos;
  int unsigned enc_clear, enc_free, enc_bits, enc_acc, enc_fill;
  bit          enc_has_prev;

  function automatic int unsigned root_bits();
    if (cur_mcs < 2) return 2;
    if (cur_mcs > 8) return 8;
    return cur_mcs;
  endfunction

  function automatic void restart_table();
    free_code = (1 << root_bits()) + 2;
    width_bits = root_bits() + 1;
    last_code = NO_CODE;
  endfunction

  function automatic int unsigned leading_pixel(int unsigned c);
    int unsigned clr;
    int unsigned guard;
    clr = 1 << root_bits();
    guard = 0;
    while (c >= clr && c < ENTRIES && guard < ENTRIES) begin
      c = code_prefix[c];
      guard++;
    end
    if (c >= clr && c < ENTRIES) return code_suffix[c];
    return c & 255;
  endfunction

  function automatic void grow_table(int unsigned ch);
    code_prefix[free_code] = last_code;
    code_suffix[free_code] = ch[7:0];
    free_code++;
    if (width_bits < WIDEST && free_code == (1 << width_bits)) width_bits++;
  endfunction

  function automatic void unwind_code(int unsigned c);
    int unsigned clr;
    clr = 1 << root_bits();
    stack_fill = 0;
    while (stack_fill < ENTRIES) begin
      if (c < clr || c >= ENTRIES) begin
        pixel_stack[stack_fill] = c[7:0];
        stack_fill++;
        break;
      end
      pixel_stack[stack_fill] = code_suffix[c];
      stack_fill++;
      c = code_prefix[c];
    end
  endfunction

  // step to the next pixel position, 1 when the image is complete
  function automatic bit step_position();
    int unsigned w, h, v;
    w = (cur_width == 0) ? 1 : cur_width;
    h = (cur_height == 0) ? 1 : cur_height;
    v = row_pos;
    col_pos++;
    if (col_pos < w) return 1'b0;
    col_pos = 0;
    if (cur_ilace) begin
      case (v & 7)
        0: begin
          v += 8;
          if (v >= h) begin
            if (h > 4) v = 4;
            else if (h > 2) v = 2;
            else if (h > 1) v = 1;
            else return 1'b1;
          end
        end
        4: begin
          v += 8;
          if (v >= h) v = 2;
        end
        2, 6: begin
          v += 4;
          if (v >= h) v = 1;
        end
        default: begin
          v += 2;
          if (v >= h) return 1'b1;
        end
      endcase
    end else begin
      v++;
      if (v >= h) return 1'b1;
    end
    row_pos = v & 16'hFFFF;
    return 1'b0;
  endfunction

  // decode buffered codes until one expands, the image ends or the buffer runs dry
  function automatic logic [2:0] decode_codes();
    int unsigned clr, c;
    while (1) begin
      clr = 1 << root_bits();
      if (width_bits == 0 || width_bits > WIDEST) restart_table();
      if (bits_held < width_bits) return ST_NEED;
      c = bit_store & ((1 << width_bits) - 1);
      bit_store = bit_store >> width_bits;
      bits_held -= width_bits;
      if (c == clr + 1) begin
        image_done = 1'b1;
        stack_fill = 0;
        return ST_FINISHED;
      end
      if (c == clr) begin
        restart_table();
        continue;
      end
      if (c < free_code) begin
        if (free_code < ENTRIES && last_code != NO_CODE) grow_table(leading_pixel(c));
      end else if (c == free_code && last_code != NO_CODE && free_code < ENTRIES) begin
        grow_table(leading_pixel(last_code));
      end else begin
        image_done = 1'b1;
        stack_fill = 0;
        return ST_SEQ_ERR;
      end
      last_code = c;
      unwind_code(c);
      return ST_PIXEL;
    end
    return ST_NEED;
  endfunction

  // predicted result of one item
  function automatic glzw_res_t decode_step(logic [1:0] k, logic [7:0] b);
    glzw_res_t r;
    logic [2:0] st;
    r = '0;
    if (k == KIND_START) begin
      restart_table();
      bit_store = 0;
      bits_held = 0;
      stack_fill = 0;
      col_pos = 0;
      row_pos = 0;
      image_done = 1'b0;
      r.status = ST_NEED;
    end else if (k == KIND_PUSH) begin
      r.status = ST_ACCEPTED;
      if (!image_done) begin
        if (bits_held >= REFUSE_AT) r.status = ST_REFUSED;
        else begin
          bit_store = (bit_store | (int'(b) << bits_held)) & 20'hFFFFF;
          bits_held += 8;
        end
      end
    end else if (image_done) begin
      r.status = ST_FINISHED;
    end else begin
      st = ST_PIXEL;
      if (stack_fill == 0) st = decode_codes();
      if (st != ST_PIXEL || stack_fill == 0) begin
        r.status = (st != ST_PIXEL) ? st : ST_NEED;
      end else begin
        stack_fill--;
        r.pixel_index = pixel_stack[stack_fill];
        r.column = 16'(cur_left + col_pos);
        r.row = 16'(cur_top + row_pos);
        if (step_position()) begin
          image_done = 1'b1;
          stack_fill = 0;
          r.last_pixel = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls and comparison against the oldest prediction
  int unsigned stall_hold;
  always @(posedge clk) begin
    glzw_res_t want;
    int unsigned r;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 8);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: status %0d", out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_pixel_index !== want.pixel_index ||
            out_column !== want.column || out_row !== want.row ||
            out_last_pixel !== want.last_pixel) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st %0d px %0d col %0d row %0d last %0b,",
                      " got st %0d px %0d col %0d row %0d last %0b"},
                     want.status, want.pixel_index, want.column, want.row,
                     want.last_pixel, out_status, out_pixel_index, out_column,
                     out_row, out_last_pixel);
        end
      end
    end
  end

  // send one item and record its prediction on acceptance
  task automatic send_item(input logic [1:0] k, input logic [7:0] b, output glzw_res_t r);
    int unsigned gap;
    in_valid <= 1'b1;
    in_kind <= k;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = decode_step(k, b);
    pending_results.push_back(r);
    items_sent++;
    if (r.status == ST_PIXEL) pixels_seen++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, drain every outstanding result and let the pipeline empty
  task automatic settle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_CODE_SIZE: cur_mcs = val[3:0];
      REG_IMAGE_LEFT:    cur_left = val;
      REG_IMAGE_TOP:     cur_top = val;
      REG_IMAGE_WIDTH:   cur_width = val;
      REG_IMAGE_HEIGHT:  cur_height = val;
      REG_INTERLACED:    cur_ilace = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup_image(input logic [3:0] mcs, input logic [15:0] left,
                             input logic [15:0] top, input logic [15:0] w,
                             input logic [15:0] h, input logic il);
    settle();
    write_reg(REG_MIN_CODE_SIZE, 16'(mcs));
    write_reg(REG_IMAGE_LEFT, left);
    write_reg(REG_IMAGE_TOP, top);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_INTERLACED, 16'(il));
  endtask

  // stream encoder mirroring the decoder's table growth
  function automatic void enc_restart();
    enc_free = enc_clear + 2;
    enc_bits = root_bits() + 1;
    enc_has_prev = 1'b0;
  endfunction

  function automatic void enc_begin();
    stream_q.delete();
    feed_pos = 0;
    enc_clear = 1 << root_bits();
    enc_acc = 0;
    enc_fill = 0;
    enc_restart();
  endfunction

  function automatic void enc_code(int unsigned c);
    enc_acc = enc_acc | (c << enc_fill);
    enc_fill += enc_bits;
    while (enc_fill >= 8) begin
      stream_q.push_back(enc_acc[7:0]);
      enc_acc = enc_acc >> 8;
      enc_fill -= 8;
    end
    if (c == enc_clear) enc_restart();
    else if (c != enc_clear + 1) begin
      if (enc_has_prev && enc_free < ENTRIES) begin
        enc_free++;
        if (enc_bits < WIDEST && enc_free == (1 << enc_bits)) enc_bits++;
      end
      enc_has_prev = 1'b1;
    end
  endfunction

  function automatic void enc_flush();
    if (enc_fill != 0) stream_q.push_back(enc_acc[7:0]);
    enc_fill = 0;
  endfunction

  // well-formed random codes, roots only when asked
  function automatic void enc_random(int unsigned n, bit roots_only);
    int unsigned c, top_code;
    for (int unsigned i = 0; i < n; i++) begin
      if (!enc_has_prev || roots_only) c = $urandom_range(0, enc_clear - 1);
      else if ($urandom_range(0, 39) == 0) c = enc_clear;
      else begin
        top_code = (enc_free < ENTRIES - 1) ? enc_free : ENTRIES - 1;
        c = $urandom_range(0, top_code);
        if (c == enc_clear || c == enc_clear + 1) c = $urandom_range(0, enc_clear - 1);
      end
      enc_code(c);
    end
  endfunction

  // push the stream and pull pixels until the image ends, the pixel cap is reached or the stream runs dry
  task automatic feed_stream(input int unsigned refuse_pct, input int unsigned pixel_cap);
    glzw_res_t r;
    int unsigned got;
    got = 0;
    while (!image_done && got < pixel_cap) begin
      if (feed_pos < stream_q.size() && (stack_fill == 0 || $urandom_range(0, 2) == 0) &&
          (bits_held < REFUSE_AT || $urandom_range(0, 99) < refuse_pct)) begin
        send_item(KIND_PUSH, stream_q[feed_pos], r);
        if (r.status == ST_ACCEPTED) feed_pos++;
      end else begin
        send_item(($urandom_range(0, 9) == 0) ? KIND_SPARE : KIND_PULL, 8'($urandom), r);
        if (r.status == ST_PIXEL) got++;
        if (r.status == ST_NEED && feed_pos >= stream_q.size()) break;
      end
    end
  endtask

  task automatic start_image();
    glzw_res_t r;
    send_item(KIND_START, 8'($urandom), r);
  endtask

  // idle decoder after reset, then a minimal image at reset settings
  task automatic test_after_reset();
    glzw_res_t r;
    send_item(KIND_PULL, 8'h00, r);
    send_item(KIND_PUSH, 8'hFF, r);
    send_item(KIND_SPARE, 8'hA5, r);
    start_image();
    send_item(KIND_PULL, 8'h00, r);
    enc_begin();
    enc_code(enc_clear);
    enc_code(255);
    enc_code(0);
    enc_flush();
    feed_stream(0, 100);
    send_item(KIND_PUSH, 8'h5A, r);
    send_item(KIND_PULL, 8'hFF, r);
  endtask

  // repeat-previous code, mid-stream clear, end code and both sequence errors
  task automatic test_code_cases();
    setup_image(4'd2, 16'd65535, 16'd65535, 16'd3, 16'd4, 1'b0);
    start_image();
    enc_begin();
    enc_code(1);
    enc_code(enc_free);
    enc_code(2);
    enc_code(enc_free);
    enc_code(enc_clear);
    enc_code(3);
    enc_code(enc_clear + 1);
    enc_code(0);
    enc_flush();
    feed_stream(30, 100);
    start_image();
    enc_begin();
    enc_code(enc_free);
    enc_flush();
    feed_stream(0, 100);
    start_image();
    enc_begin();
    enc_code(0);
    enc_code((1 << enc_bits) - 1);
    enc_flush();
    feed_stream(0, 100);
  endtask

  // row order for small heights, both progressive and interlaced
  task automatic test_row_order();
    int unsigned heights[11] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 17, 0};
    foreach (heights[i]) begin
      setup_image(4'($urandom_range(2, 8)), 16'($urandom), 16'($urandom),
                  16'($urandom_range(0, 2)), 16'(heights[i]), ($urandom_range(0, 3) != 0));
      start_image();
      enc_begin();
      enc_random(40, 1'b0);
      enc_flush();
      feed_stream(10, 1000);
    end
  endtask

  // shrinking the image while it is being decoded
  task automatic test_live_resize();
    setup_image(4'd3, 16'd10, 16'd20, 16'd5, 16'd5, 1'b0);
    start_image();
    enc_begin();
    enc_random(30, 1'b0);
    enc_flush();
    feed_stream(0, 8);
    setup_image(4'd3, 16'd10, 16'd20, 16'd2, 16'd1, 1'b0);
    feed_stream(0, 1000);
  endtask

  // minimum code sizes outside the legal range, and the widest root set
  task automatic test_code_size_limits();
    logic [3:0] sizes[5] = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15};
    foreach (sizes[i]) begin
      setup_image(sizes[i], 16'd0, 16'd0, 16'd4, 16'd3, 1'b0);
      start_image();
      enc_begin();
      enc_random(20, 1'b0);
      enc_code(enc_clear + 1);
      enc_flush();
      feed_stream(0, 1000);
    end
  endtask

  // random images, mostly well formed, with noise and broken streams
  task automatic test_random();
    glzw_res_t r;
    int unsigned base, mode;
    base = items_sent;
    while (items_sent - base < 150) begin
      quiet = ($urandom_range(0, 4) == 0);
      setup_image(($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(2, 8)),
                  16'($urandom), 16'($urandom),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                  16'($urandom_range(0, 10)), 1'($urandom));
      start_image();
      mode = $urandom_range(0, 9);
      enc_begin();
      if (mode == 0) begin
        repeat ($urandom_range(2, 12)) stream_q.push_back(8'($urandom));
      end else begin
        enc_random($urandom_range(3, 40), 1'b0);
        if (mode == 1) enc_code(enc_clear + 1 + $urandom_range(1, 4));
        else if (mode < 5) enc_code(enc_clear + 1);
        enc_flush();
      end
      feed_stream(8, 1000);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(2, 8)) send_item(2'($urandom), 8'($urandom), r);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_PULL;
    in_data_byte <= 8'h00;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MIN_CODE_SIZE;
    cfg_data <= 16'h0000;
    stall_hold = 0;
    cycles = 0;
    items_sent = 0;
    pixels_seen = 0;
    mismatches = 0;
    quiet = 1'b0;
    cur_mcs = 4'd8;
    cur_left = 16'd0;
    cur_top = 16'd0;
    cur_width = 16'd1;
    cur_height = 16'd1;
    cur_ilace = 1'b0;
    foreach (code_prefix[i]) begin
      code_prefix[i] = 0;
      code_suffix[i] = 8'h00;
      pixel_stack[i] = 8'h00;
    end
    stack_fill = 0;
    free_code = 0;
    width_bits = 0;
    last_code = NO_CODE;
    bit_store = 0;
    bits_held = 0;
    col_pos = 0;
    row_pos = 0;
    image_done = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_code_cases();
    test_row_order();
    test_live_resize();
    test_code_size_limits();
    test_random();

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
